[design/differential_drive_mixer_core_defines.svh]
// Assertion macros for the differential drive mixer.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef DIFFERENTIAL_DRIVE_MIXER_CORE_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_MIXER_CORE_DEFINES_SVH

// same-cycle implication
`define DDM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ddm check failed");

// next-cycle implication
`define DDM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ddm check failed");

`endif

[design/ddm_pkg.sv]
// Shared types, widths and constants of the differential drive mixer.
// No dependencies.
package ddm_pkg;

  localparam int VEL_FRAC_BITS  = 12;
  localparam int GAIN_FRAC_BITS = 12;
  localparam int DEN_SHIFT      = VEL_FRAC_BITS + GAIN_FRAC_BITS;

  localparam int VEL_W  = 16;
  localparam int CFG_W  = 15;
  localparam int GAIN_W = 16;
  localparam int WDATA_W = 16;
  localparam int SPD_W  = 8;

  // |mix| < 2^31 + 2^27
  localparam int MAG_W  = 32;
  localparam int SUM_W  = MAG_W + 2;

  localparam int SPEED_SCALE = 100;
  localparam int SCALE_SQ    = 10000;
  localparam int PROD_P_W    = MAG_W + 7;
  localparam int PROD_R_W    = MAG_W + 14;
  localparam int PA_W        = PROD_P_W - DEN_SHIFT;
  localparam int RA_W        = PROD_R_W - DEN_SHIFT;
  localparam int IA_W        = PA_W;
  localparam int DIV_W       = IA_W + 2;

  // floor(n/3) = (n * RECIP_THIRD) >> RECIP_SHIFT, exact for n < 2^RECIP_SHIFT
  localparam int RECIP_SHIFT = 17;
  localparam int RECIP_THIRD = 43691;
  localparam int RECIP_W     = PA_W + RECIP_SHIFT;

  // deadband: 20*|v| > 2^VEL_FRAC_BITS
  localparam int DB_W  = VEL_W + 6;
  localparam int DB_TH = 1 << VEL_FRAC_BITS;

  // divider: quotient bits, two per step
  localparam int Q_W   = 8;
  localparam int DSH_W = DIV_W + Q_W - 1;
  localparam int QO_W  = 7;

  typedef enum logic [2:0] {
    REG_MIN_LINEAR  = 3'd0,
    REG_MAX_LINEAR  = 3'd1,
    REG_MIN_ANGULAR = 3'd2,
    REG_MAX_ANGULAR = 3'd3,
    REG_TURN_GAIN   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [CFG_W-1:0]  min_lin;
    logic [CFG_W-1:0]  max_lin;
    logic [CFG_W-1:0]  min_ang;
    logic [CFG_W-1:0]  max_ang;
    logic [GAIN_W-1:0] gain;
  } cfg_t;

  typedef struct packed {
    logic              a_neg;
    logic              b_neg;
    logic              fault;
    logic              rescale;
    logic [QO_W-1:0]   ia;
    logic [QO_W-1:0]   ib;
    logic [RA_W-1:0]   ra;
    logic [RA_W-1:0]   rb;
    logic [DIV_W-1:0]  divisor;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic busy;
    logic pop;
    logic finish;
  } bk_stat_t;

endpackage

[design/ddm_front.sv]
// Front pipeline: bounds the commands, mixes them, scales and classifies each beat.
// Depends on ddm_pkg; feeds ddm_queue.
module ddm_front
  import ddm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [VEL_W-1:0] lin_i,
  input  logic signed [VEL_W-1:0] ang_i,
  input  logic                    full_i,
  output logic                    push_o,
  output job_t                    job_o
);

  localparam int NSTG = 6;

  function automatic logic signed [VEL_W-1:0] bound_cmd(
    input logic signed [VEL_W-1:0] v,
    input logic [CFG_W-1:0]        lo,
    input logic [CFG_W-1:0]        hi
  );
    logic [VEL_W:0]          mag;
    logic [DB_W-1:0]         mag20;
    logic [VEL_W-1:0]        lim;
    logic                    clip;
    logic signed [VEL_W-1:0] res;
    mag   = v[VEL_W-1] ? ((VEL_W+1)'(0) - {v[VEL_W-1], v}) : {1'b0, v};
    mag20 = DB_W'({mag, 4'b0}) + DB_W'({mag, 2'b0});
    clip  = 1'b0;
    lim   = '0;
    if (mag20 > DB_W'(DB_TH)) begin
      if (mag < (VEL_W+1)'(lo)) begin
        clip = 1'b1;
        lim  = VEL_W'(lo);
      end else if (mag > (VEL_W+1)'(hi)) begin
        clip = 1'b1;
        lim  = VEL_W'(hi);
      end
    end
    if (!clip) res = v;
    else if (v[VEL_W-1]) res = VEL_W'(0) - lim;
    else res = lim;
    return res;
  endfunction

  logic [NSTG-1:0] vld_q, vld_d;
  logic            en;

  logic signed [VEL_W-1:0] x1_q, z1_q;
  logic                    f1_q;
  logic signed [VEL_W-1:0] x2_q;
  logic signed [MAG_W:0]   zg2_q;
  logic                    f2_q;
  logic signed [SUM_W-1:0] a3_q, b3_q;
  logic                    f3_q;
  logic [MAG_W-1:0]        ma4_q, mb4_q;
  logic                    an4_q, bn4_q, f4_q;
  logic [PA_W-1:0]         pa5_q, pb5_q;
  logic [RA_W-1:0]         ra5_q, rb5_q;
  logic                    an5_q, bn5_q, f5_q;
  logic [IA_W-1:0]         ia6_q, ib6_q;
  logic [RA_W-1:0]         ra6_q, rb6_q;
  logic                    an6_q, bn6_q, f6_q;

  logic                    fl, fa;
  logic signed [MAG_W:0]   zg;
  logic signed [SUM_W-1:0] xs_e, zg_e;
  logic [PROD_P_W-1:0]     prod_pa, prod_pb;
  logic [PROD_R_W-1:0]     prod_ra, prod_rb;
  logic [RECIP_W-1:0]      prod_ta, prod_tb;
  logic [IA_W-1:0]         top;

  assign en         = !vld_q[NSTG-1] || !full_i;
  assign in_ready_o = en;
  assign push_o     = vld_q[NSTG-1] && !full_i;
  assign vld_d      = {vld_q[NSTG-2:0], in_valid_i};

  assign fl = cfg_i.min_lin > cfg_i.max_lin;
  assign fa = cfg_i.min_ang > cfg_i.max_ang;
  assign zg = $signed(z1_q) * $signed({1'b0, cfg_i.gain});
  assign xs_e = {{(SUM_W-VEL_W-GAIN_FRAC_BITS){x2_q[VEL_W-1]}}, x2_q,
                 {GAIN_FRAC_BITS{1'b0}}};
  assign zg_e = {{(SUM_W-MAG_W-1){zg2_q[MAG_W]}}, zg2_q};

  assign prod_pa = PROD_P_W'(ma4_q) * PROD_P_W'(SPEED_SCALE);
  assign prod_pb = PROD_P_W'(mb4_q) * PROD_P_W'(SPEED_SCALE);
  assign prod_ra = PROD_R_W'(ma4_q) * PROD_R_W'(SCALE_SQ);
  assign prod_rb = PROD_R_W'(mb4_q) * PROD_R_W'(SCALE_SQ);
  assign prod_ta = RECIP_W'(pa5_q) * RECIP_W'(RECIP_THIRD);
  assign prod_tb = RECIP_W'(pb5_q) * RECIP_W'(RECIP_THIRD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q  <= fl ? '0 : bound_cmd(lin_i, cfg_i.min_lin, cfg_i.max_lin);
      z1_q  <= fa ? '0 : bound_cmd(ang_i, cfg_i.min_ang, cfg_i.max_ang);
      f1_q  <= fl || fa;
      x2_q  <= x1_q;
      zg2_q <= zg;
      f2_q  <= f1_q;
      a3_q  <= SUM_W'(0) - xs_e - zg_e;
      b3_q  <= zg_e - xs_e;
      f3_q  <= f2_q;
      an4_q <= a3_q[SUM_W-1];
      bn4_q <= b3_q[SUM_W-1];
      ma4_q <= a3_q[SUM_W-1] ? MAG_W'(SUM_W'(0) - a3_q) : MAG_W'(a3_q);
      mb4_q <= b3_q[SUM_W-1] ? MAG_W'(SUM_W'(0) - b3_q) : MAG_W'(b3_q);
      f4_q  <= f3_q;
      pa5_q <= prod_pa[PROD_P_W-1:DEN_SHIFT];
      pb5_q <= prod_pb[PROD_P_W-1:DEN_SHIFT];
      ra5_q <= prod_ra[PROD_R_W-1:DEN_SHIFT];
      rb5_q <= prod_rb[PROD_R_W-1:DEN_SHIFT];
      an5_q <= an4_q;
      bn5_q <= bn4_q;
      f5_q  <= f4_q;
      ia6_q <= prod_ta[RECIP_W-1:RECIP_SHIFT];
      ib6_q <= prod_tb[RECIP_W-1:RECIP_SHIFT];
      ra6_q <= ra5_q;
      rb6_q <= rb5_q;
      an6_q <= an5_q;
      bn6_q <= bn5_q;
      f6_q  <= f5_q;
    end
  end

  always_comb begin
    top           = (ia6_q > ib6_q) ? ia6_q : ib6_q;
    job_o.a_neg   = an6_q;
    job_o.b_neg   = bn6_q;
    job_o.fault   = f6_q;
    job_o.rescale = top > IA_W'(SPEED_SCALE);
    job_o.ia      = ia6_q[QO_W-1:0];
    job_o.ib      = ib6_q[QO_W-1:0];
    job_o.ra      = ra6_q;
    job_o.rb      = rb6_q;
    job_o.divisor = DIV_W'({top, 1'b0}) + DIV_W'(top);
  end

endmodule

[design/ddm_queue.sv]
// Job queue between the front pipeline and the back end.
// Depends on ddm_pkg.
module ddm_queue
  import ddm_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  job_t    push_job_i,
  input  logic    pop_i,
  output job_t    head_o,
  output q_stat_t stat_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign head_o       = mem_q[rd_q];
  assign stat_o.full  = cnt_q == CNT_W'(DEPTH);
  assign stat_o.empty = cnt_q == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_job_i;
  end

endmodule

[design/ddm_back.sv]
// Back end: rescale divider (two quotient bits per cycle; a busy output holds
// its last step) and output register. Depends on ddm_pkg; pops ddm_queue jobs.
module ddm_back
  import ddm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  job_t              head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output bk_stat_t          stat_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [SPD_W-1:0]  spd_a_o,
  output logic [SPD_W-1:0]  spd_b_o,
  output logic              fault_o
);

  function automatic logic [RA_W+1:0] div_step(
    input logic [RA_W-1:0]  rem,
    input logic [DSH_W-1:0] dsh
  );
    logic [DSH_W-1:0] r0, r1, r2, d1;
    logic             b1, b0;
    r0 = DSH_W'(rem);
    d1 = dsh >> 1;
    b1 = r0 >= dsh;
    r1 = b1 ? r0 - dsh : r0;
    b0 = r1 >= d1;
    r2 = b0 ? r1 - d1 : r1;
    return {RA_W'(r2), b1, b0};
  endfunction

  logic              busy_q, busy_d;
  logic [1:0]        cnt_q;
  logic [RA_W-1:0]   rem_a_q, rem_b_q;
  logic [DSH_W-1:0]  dsh_q;
  logic [Q_W-1:0]    qa_q, qb_q;
  logic              an_q, bn_q, f_q;
  logic              ov_q;
  logic [SPD_W-1:0]  oa_q, ob_q;
  logic              of_q;

  logic              out_free, finish, step_en, load;
  logic [RA_W+1:0]   sa, sb;
  logic [Q_W-1:0]    qa_fin, qb_fin;

  assign out_free = !ov_q || out_ready_i;
  assign finish   = busy_q && (cnt_q == 2'd3) && out_free;
  assign step_en  = busy_q && ((cnt_q != 2'd3) || out_free);
  assign pop_o    = !empty_i && (head_i.rescale ? (!busy_q || finish)
                                                : (!busy_q && out_free));
  assign load     = pop_o && head_i.rescale;
  assign busy_d   = load ? 1'b1 : (finish ? 1'b0 : busy_q);

  assign sa     = div_step(rem_a_q, dsh_q);
  assign sb     = div_step(rem_b_q, dsh_q);
  assign qa_fin = {qa_q[Q_W-3:0], sa[1:0]};
  assign qb_fin = {qb_q[Q_W-3:0], sb[1:0]};

  assign stat_o.busy   = busy_q;
  assign stat_o.pop    = pop_o;
  assign stat_o.finish = finish;

  assign out_valid_o = ov_q;
  assign spd_a_o     = oa_q;
  assign spd_b_o     = ob_q;
  assign fault_o     = of_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (load) cnt_q <= '0;
      else if (step_en) cnt_q <= cnt_q + 1'b1;
      if (finish || (pop_o && !head_i.rescale)) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_a_q <= head_i.ra;
      rem_b_q <= head_i.rb;
      dsh_q   <= DSH_W'(head_i.divisor) << (Q_W - 1);
      qa_q    <= '0;
      qb_q    <= '0;
      an_q    <= head_i.a_neg;
      bn_q    <= head_i.b_neg;
      f_q     <= head_i.fault;
    end else if (step_en) begin
      rem_a_q <= sa[RA_W+1:2];
      rem_b_q <= sb[RA_W+1:2];
      dsh_q   <= dsh_q >> 2;
      qa_q    <= qa_fin;
      qb_q    <= qb_fin;
    end
    if (finish) begin
      oa_q <= an_q ? SPD_W'(0) - SPD_W'(qa_fin) : SPD_W'(qa_fin);
      ob_q <= bn_q ? SPD_W'(0) - SPD_W'(qb_fin) : SPD_W'(qb_fin);
      of_q <= f_q;
    end else if (pop_o && !head_i.rescale) begin
      oa_q <= head_i.a_neg ? SPD_W'(0) - SPD_W'(head_i.ia) : SPD_W'(head_i.ia);
      ob_q <= head_i.b_neg ? SPD_W'(0) - SPD_W'(head_i.ib) : SPD_W'(head_i.ib);
      of_q <= head_i.fault;
    end
  end

endmodule

[design/differential_drive_mixer_core.sv]
// Differential drive mixer top: config registers, front pipeline, job queue, back end.
// Each beat passes the front pipeline, job queue and output register, a rescale beat also
// the divider. Throughput: one beat per cycle for plain beats while the output is ready
// and no divide runs; a rescale beat holds the divider; the next one loads as it finishes.
// Reset (async, active low) empties pipeline, queue and output; config regs go to defaults.
`include "differential_drive_mixer_core_defines.svh"
module differential_drive_mixer_core
  import ddm_pkg::*;
#(
  parameter int FIFO_DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_addr_i,
  input  logic [WDATA_W-1:0]  cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,   // linear_velocity, angular_velocity
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,   // motor_a_speed, motor_b_speed
  output logic                m_axis_tuser    // range_fault
);

  cfg_t     cfg_q;
  logic     push, pop;
  job_t     push_job, q_head;
  q_stat_t  q_stat;
  bk_stat_t bk_stat;
  logic     spd_in_range;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_lin <= CFG_W'(0);
      cfg_q.max_lin <= CFG_W'(4096);
      cfg_q.min_ang <= CFG_W'(0);
      cfg_q.max_ang <= CFG_W'(4096);
      cfg_q.gain    <= GAIN_W'(12288);
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_MIN_LINEAR:  cfg_q.min_lin <= cfg_wdata_i[CFG_W-1:0];
        REG_MAX_LINEAR:  cfg_q.max_lin <= cfg_wdata_i[CFG_W-1:0];
        REG_MIN_ANGULAR: cfg_q.min_ang <= cfg_wdata_i[CFG_W-1:0];
        REG_MAX_ANGULAR: cfg_q.max_ang <= cfg_wdata_i[CFG_W-1:0];
        REG_TURN_GAIN:   cfg_q.gain    <= cfg_wdata_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  ddm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .lin_i      (s_axis_tdata[15:0]),
    .ang_i      (s_axis_tdata[31:16]),
    .full_i     (q_stat.full),
    .push_o     (push),
    .job_o      (push_job)
  );

  ddm_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (q_head),
    .stat_o     (q_stat)
  );

  ddm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .empty_i     (q_stat.empty),
    .pop_o       (pop),
    .stat_o      (bk_stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .spd_a_o     (m_axis_tdata[7:0]),
    .spd_b_o     (m_axis_tdata[15:8]),
    .fault_o     (m_axis_tuser)
  );

  assign spd_in_range = ($signed(m_axis_tdata[7:0]) <= 8'sd100) &&
                        ($signed(m_axis_tdata[7:0]) >= -8'sd100) &&
                        ($signed(m_axis_tdata[15:8]) <= 8'sd100) &&
                        ($signed(m_axis_tdata[15:8]) >= -8'sd100);

  `DDM_ASSERT_NOW(a_spd_range, m_axis_tvalid, spd_in_range)
  `DDM_ASSERT_NOW(a_pop_nonempty, bk_stat.pop, !q_stat.empty)
  `DDM_ASSERT_NOW(a_busy_pop_rescale, bk_stat.pop && bk_stat.busy, q_head.rescale)
  `DDM_ASSERT_NEXT(a_finish_out, bk_stat.finish, m_axis_tvalid)

endmodule
